// ----- hw/rtl/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants for the line segment clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int CW = 16;          // coordinate width
    localparam int EW = CW + 2;      // coordinate difference width
    localparam int PW = 2 * EW;      // product width
    localparam int MW = PW - 1;      // product magnitude width
    localparam int RW = EW + 1;      // divider remainder width
    localparam int DCW = $clog2(MW); // divider step counter width
    localparam int FIFO_DEPTH = 2;
    localparam int CLIP_ROUNDS = 5;

    localparam logic [3:0] CODE_LEFT   = 4'd1;
    localparam logic [3:0] CODE_RIGHT  = 4'd2;
    localparam logic [3:0] CODE_BOTTOM = 4'd4;
    localparam logic [3:0] CODE_TOP    = 4'd8;

    localparam logic [1:0] CFG_XMIN = 2'd0;
    localparam logic [1:0] CFG_XMAX = 2'd1;
    localparam logic [1:0] CFG_YMIN = 2'd2;
    localparam logic [1:0] CFG_YMAX = 2'd3;

    localparam logic signed [CW-1:0] RST_XMIN = CW'(0);
    localparam logic signed [CW-1:0] RST_XMAX = CW'(1023);
    localparam logic signed [CW-1:0] RST_YMIN = CW'(0);
    localparam logic signed [CW-1:0] RST_YMAX = CW'(1023);

    typedef struct packed {
        logic signed [CW-1:0] vertex_x;
        logic signed [CW-1:0] vertex_y;
        logic                 starts_polyline;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 is_last;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
    } t_seg;

    typedef struct packed {
        logic signed [CW-1:0] xmin;
        logic signed [CW-1:0] xmax;
        logic signed [CW-1:0] ymin;
        logic signed [CW-1:0] ymax;
    } t_win;

    typedef struct packed {
        logic valid;
        t_seg seg;
    } t_push;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_OUT0,
        ST_OUT1
    } t_state;

    function automatic logic [3:0] outcode(input logic signed [CW-1:0] x,
                                           input logic signed [CW-1:0] y,
                                           input t_win w);
        logic [3:0] c;
        c = 4'd0;
        if (x < w.xmin) c = c | CODE_LEFT;
        if (x > w.xmax) c = c | CODE_RIGHT;
        if (y < w.ymin) c = c | CODE_BOTTOM;
        if (y > w.ymax) c = c | CODE_TOP;
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/line_segment_clipper.sv -----
// ----------------------------------------------------------------------------
// line_segment_clipper
// Polyline segment clipper against a configurable rectangular window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/i_data/o_stall carries one vertex per transfer.
//   A vertex with starts_polyline set, or the first after reset, only
//   becomes the previous vertex; every other vertex forms a segment with it.
//   Output channel o_valid/o_data/i_stall carries clipped endpoints: two
//   transfers per accepted segment, the second with is_last set; a rejected
//   segment yields nothing.
//   Window registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata;
//   the user must do so only while the block is idle, unchecked by the block.
//   A segment inside the window passes from the queue through the decide
//   state to its first endpoint. Each clip round runs decide, multiply,
//   divider load, 35 one-bit divide steps and update, for up to five
//   rounds. The front takes a vertex per cycle while the two-entry
//   segment queue has room; the divider sets sustained throughput.
//   Reset (synchronous, active low) clears the previous vertex, the queue
//   and the engine, and loads the default 0..1023 window.
//   While i_stall is high the current endpoint holds on o_data.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_clipper (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire lsc_pkg::t_in              i_data,
    output logic                           o_stall,
    output logic                           o_valid,
    output lsc_pkg::t_out                  o_data,
    input  wire logic                      i_stall,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_addr,
    input  wire logic [lsc_pkg::CW-1:0]    i_cfg_wdata
);

    lsc_pkg::t_win  r_win;
    lsc_pkg::t_push w_push;
    lsc_pkg::t_seg  w_seg;
    logic           w_full, w_empty, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.xmin <= lsc_pkg::RST_XMIN;
            r_win.xmax <= lsc_pkg::RST_XMAX;
            r_win.ymin <= lsc_pkg::RST_YMIN;
            r_win.ymax <= lsc_pkg::RST_YMAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lsc_pkg::CFG_XMIN: r_win.xmin <= i_cfg_wdata;
                lsc_pkg::CFG_XMAX: r_win.xmax <= i_cfg_wdata;
                lsc_pkg::CFG_YMIN: r_win.ymin <= i_cfg_wdata;
                lsc_pkg::CFG_YMAX: r_win.ymax <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    lsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    lsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_seg   (w_seg)
    );

    lsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_empty (w_empty),
        .i_seg   (w_seg),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lsc_front.sv -----
// ----------------------------------------------------------------------------
// lsc_front
// Accepts vertices, keeps the previous raw vertex and forms segments.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire lsc_pkg::t_in i_data,
    output logic              o_stall,
    input  wire logic         i_full,
    output lsc_pkg::t_push    o_push
);

    logic                         r_prev_valid;
    logic signed [lsc_pkg::CW-1:0] r_prev_x;
    logic signed [lsc_pkg::CW-1:0] r_prev_y;
    logic                         w_take;

    assign o_stall = i_full;
    assign w_take  = i_valid && !i_full;

    always_comb begin
        o_push.valid  = w_take && r_prev_valid && !i_data.starts_polyline;
        o_push.seg.x1 = r_prev_x;
        o_push.seg.y1 = r_prev_y;
        o_push.seg.x2 = i_data.vertex_x;
        o_push.seg.y2 = i_data.vertex_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
        end else if (w_take) begin
            r_prev_valid <= 1'b1;
            r_prev_x     <= i_data.vertex_x;
            r_prev_y     <= i_data.vertex_y;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lsc_fifo.sv -----
// ----------------------------------------------------------------------------
// lsc_fifo
// Short segment queue between the front and the clipping engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lsc_pkg::t_push i_push,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output lsc_pkg::t_seg      o_seg
);

    localparam int AW = $clog2(lsc_pkg::FIFO_DEPTH);

    lsc_pkg::t_seg  r_mem [lsc_pkg::FIFO_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           w_pop;

    assign o_full  = r_cnt == (AW+1)'(lsc_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_seg   = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) r_wp <= r_wp + AW'(1);
            if (w_pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push.valid) - (AW+1)'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(lsc_pkg::FIFO_DEPTH))
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ----- hw/rtl/lsc_back.sv -----
// ----------------------------------------------------------------------------
// lsc_back
// Clipping engine: outcodes, edge moves through a shared multiply and
// iterative divide, and output of the two clipped endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lsc_pkg::t_win i_win,
    input  wire logic          i_empty,
    input  wire lsc_pkg::t_seg i_seg,
    output logic               o_pop,
    output logic               o_valid,
    output lsc_pkg::t_out      o_data,
    input  wire logic          i_stall
);

    localparam int CW  = lsc_pkg::CW;
    localparam int EW  = lsc_pkg::EW;
    localparam int PW  = lsc_pkg::PW;
    localparam int MW  = lsc_pkg::MW;
    localparam int RW  = lsc_pkg::RW;
    localparam int DCW = lsc_pkg::DCW;

    lsc_pkg::t_state r_state, n_state;

    logic signed [CW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [2:0]           r_round;
    logic                 r_first, r_yedge, r_neg;
    logic signed [CW-1:0] r_q1, r_edge;
    logic signed [EW-1:0] r_dq, r_diff, r_de;
    logic signed [PW-1:0] r_prod;
    logic [MW-1:0]        r_dvd, r_quo;
    logic [EW-1:0]        r_dvs;
    logic [RW-1:0]        r_rem;
    logic [DCW-1:0]       r_cnt;

    logic [3:0]           w_c1, w_c2, w_co;
    logic                 w_yedge;
    logic signed [CW-1:0] w_q1, w_q2, w_e1, w_e2, w_edge;
    logic [RW-1:0]        w_trial;
    logic                 w_ge;
    logic signed [MW:0]   w_qs;
    logic signed [MW:0]   w_sum;
    logic signed [CW-1:0] w_nv;

    always_comb begin
        w_c1    = lsc_pkg::outcode(r_x1, r_y1, i_win);
        w_c2    = lsc_pkg::outcode(r_x2, r_y2, i_win);
        w_co    = (w_c1 != 4'd0) ? w_c1 : w_c2;
        w_yedge = |(w_co & (lsc_pkg::CODE_TOP | lsc_pkg::CODE_BOTTOM));
        if ((w_co & lsc_pkg::CODE_TOP) != 4'd0)         w_edge = i_win.ymax;
        else if ((w_co & lsc_pkg::CODE_BOTTOM) != 4'd0) w_edge = i_win.ymin;
        else if ((w_co & lsc_pkg::CODE_RIGHT) != 4'd0)  w_edge = i_win.xmax;
        else                                            w_edge = i_win.xmin;
        w_q1 = w_yedge ? r_x1 : r_y1;
        w_q2 = w_yedge ? r_x2 : r_y2;
        w_e1 = w_yedge ? r_y1 : r_x1;
        w_e2 = w_yedge ? r_y2 : r_x2;

        w_trial = {r_rem[RW-2:0], r_dvd[MW-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};

        w_qs  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        w_sum = {{(MW+1-CW){r_q1[CW-1]}}, r_q1} + w_qs;
        w_nv  = (r_de == '0) ? r_q1 : w_sum[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_valid = 1'b0;
        o_data  = '0;
        unique case (r_state)
            lsc_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = lsc_pkg::ST_DECIDE;
                end
            end
            lsc_pkg::ST_DECIDE: begin
                if (w_c1 == 4'd0 && w_c2 == 4'd0) begin
                    n_state = lsc_pkg::ST_OUT0;
                end else if ((w_c1 & w_c2) != 4'd0 ||
                             r_round == 3'(lsc_pkg::CLIP_ROUNDS)) begin
                    n_state = lsc_pkg::ST_IDLE;
                end else begin
                    n_state = lsc_pkg::ST_MUL;
                end
            end
            lsc_pkg::ST_MUL: n_state = lsc_pkg::ST_DIV;
            lsc_pkg::ST_DIV: begin
                if (r_cnt == DCW'(MW)) n_state = lsc_pkg::ST_UPD;
            end
            lsc_pkg::ST_UPD: n_state = lsc_pkg::ST_DECIDE;
            lsc_pkg::ST_OUT0: begin
                o_valid        = 1'b1;
                o_data.point_x = r_x1;
                o_data.point_y = r_y1;
                o_data.is_last = 1'b0;
                if (!i_stall) n_state = lsc_pkg::ST_OUT1;
            end
            lsc_pkg::ST_OUT1: begin
                o_valid        = 1'b1;
                o_data.point_x = r_x2;
                o_data.point_y = r_y2;
                o_data.is_last = 1'b1;
                if (!i_stall) n_state = lsc_pkg::ST_IDLE;
            end
            default: n_state = lsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lsc_pkg::ST_IDLE: begin
                r_x1    <= i_seg.x1;
                r_y1    <= i_seg.y1;
                r_x2    <= i_seg.x2;
                r_y2    <= i_seg.y2;
                r_round <= '0;
            end
            lsc_pkg::ST_DECIDE: begin
                r_first <= w_c1 != 4'd0;
                r_yedge <= w_yedge;
                r_q1    <= w_q1;
                r_edge  <= w_edge;
                r_dq    <= EW'(w_q2) - EW'(w_q1);
                r_diff  <= EW'(w_edge) - EW'(w_e1);
                r_de    <= EW'(w_e2) - EW'(w_e1);
            end
            lsc_pkg::ST_MUL: begin
                r_prod <= r_dq * r_diff;
            end
            lsc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    r_neg <= r_prod[PW-1] ^ r_de[EW-1];
                    r_dvd <= r_prod[PW-1] ? MW'(-r_prod) : MW'(r_prod);
                    r_dvs <= r_de[EW-1] ? EW'(-r_de) : EW'(r_de);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= r_cnt + DCW'(1);
                end else begin
                    r_rem <= w_ge ? (w_trial - {1'b0, r_dvs}) : w_trial;
                    r_quo <= {r_quo[MW-2:0], w_ge};
                    r_dvd <= {r_dvd[MW-2:0], 1'b0};
                    r_cnt <= (r_cnt == DCW'(MW)) ? r_cnt : r_cnt + DCW'(1);
                end
            end
            lsc_pkg::ST_UPD: begin
                r_round <= r_round + 3'd1;
                if (r_first) begin
                    r_x1 <= r_yedge ? w_nv : r_edge;
                    r_y1 <= r_yedge ? r_edge : w_nv;
                end else begin
                    r_x2 <= r_yedge ? w_nv : r_edge;
                    r_y2 <= r_yedge ? r_edge : w_nv;
                end
            end
            default: ;
        endcase
        if (r_state == lsc_pkg::ST_MUL) r_cnt <= '0;
    end

    a_out1_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsc_pkg::ST_OUT1 |->
            ($past(r_state) == lsc_pkg::ST_OUT0 || $past(r_state) == lsc_pkg::ST_OUT1))
        else $error("second endpoint without first");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsc_pkg::ST_MUL |-> r_round < 3'(lsc_pkg::CLIP_ROUNDS))
        else $error("clip round beyond bound");

endmodule

`default_nettype wire
